>>> rtl/acp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_pkg: shared types and constants of the ATAPI CD-ROM command responder
// Holds the event and opcode codes, the sense codes, the descriptor that
// passes from the command front to the response back, and the byte tables.
// ----------------------------------------------------------------------------
package acp_pkg;

	// Logical block size reported by READ CAPACITY and used by READ(10).
	localparam int SECTOR_BYTES = 2048;

	localparam int XFER_W = 27;
	localparam logic [XFER_W-1:0] XFER_MAX = '1;

	// Descriptor queue between the front and the back (power of two).
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Byte index within a response (36 bytes at most).
	localparam int IDX_W = 6;

	// Input event kinds.
	localparam logic [1:0] EV_CMD    = 2'd0;
	localparam logic [1:0] EV_RESET  = 2'd1;
	localparam logic [1:0] EV_INSERT = 2'd2;
	localparam logic [1:0] EV_EJECT  = 2'd3;

	// Packet opcodes.
	localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
	localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
	localparam logic [7:0] OP_INQUIRY         = 8'h12;
	localparam logic [7:0] OP_START_STOP      = 8'h1B;
	localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
	localparam logic [7:0] OP_READ10          = 8'h28;
	localparam logic [7:0] OP_READ_TOC        = 8'h43;
	localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;

	// Sense keys and additional sense codes.
	localparam logic [3:0] KEY_NONE      = 4'h0;
	localparam logic [3:0] KEY_NOT_READY = 4'h2;
	localparam logic [3:0] KEY_ILLEGAL   = 4'h5;
	localparam logic [3:0] KEY_ATTENTION = 4'h6;

	localparam logic [7:0] ASC_NONE           = 8'h00;
	localparam logic [7:0] ASC_INVALID_OPCODE = 8'h20;
	localparam logic [7:0] ASC_LBA_RANGE      = 8'h21;
	localparam logic [7:0] ASC_INVALID_FIELD  = 8'h24;
	localparam logic [7:0] ASC_DISC_CHANGED   = 8'h28;
	localparam logic [7:0] ASC_NO_MEDIUM      = 8'h3A;

	// Response lengths in bytes.
	localparam logic [IDX_W-1:0] LEN_SENSE = 6'd18;
	localparam logic [IDX_W-1:0] LEN_INQ   = 6'd36;
	localparam logic [IDX_W-1:0] LEN_CAP   = 6'd8;
	localparam logic [IDX_W-1:0] LEN_TOC   = 6'd20;
	localparam logic [IDX_W-1:0] LEN_MODE  = 6'd8;

	localparam logic [223:0] IDENT_TEXT = "GENERIC ATAPI CD-ROM    1.00";

	typedef enum logic [2:0] {
		RSP_NONE  = 3'd0,
		RSP_SENSE = 3'd1,
		RSP_INQ   = 3'd2,
		RSP_CAP   = 3'd3,
		RSP_TOC   = 3'd4,
		RSP_MODE  = 3'd5
	} rsp_kind_t;

	// One command as the back needs it: snapshot of sense and disc size
	// taken when the command was accepted.
	typedef struct packed {
		rsp_kind_t         rsp;
		logic              status;
		logic [XFER_W-1:0] xfer;
		logic [3:0]        key;
		logic [7:0]        code;
		logic [7:0]        qual;
		logic [31:0]       sectors;
	} cmd_desc_t;

	function automatic logic [IDX_W-1:0] rsp_len(input rsp_kind_t rsp);
		logic [IDX_W-1:0] n;
		case (rsp)
			RSP_SENSE: n = LEN_SENSE;
			RSP_INQ:   n = LEN_INQ;
			RSP_CAP:   n = LEN_CAP;
			RSP_TOC:   n = LEN_TOC;
			RSP_MODE:  n = LEN_MODE;
			default:   n = 6'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] ident_byte(input logic [IDX_W-1:0] idx);
		logic [4:0] i;
		i = 5'(idx - 6'd8);
		return IDENT_TEXT[223 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] be32_byte(input logic [31:0] v, input logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0:    b = v[31:24];
			2'd1:    b = v[23:16];
			2'd2:    b = v[15:8];
			default: b = v[7:0];
		endcase
		return b;
	endfunction

	// Response byte idx of descriptor d.
	function automatic logic [7:0] rsp_byte(input cmd_desc_t d, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (d.rsp)
			RSP_SENSE: begin
				case (idx)
					6'd0:    b = 8'h70;
					6'd2:    b = {4'h0, d.key};
					6'd7:    b = 8'd10;
					6'd12:   b = d.code;
					6'd13:   b = d.qual;
					default: b = 8'h00;
				endcase
			end
			RSP_INQ: begin
				case (idx)
					6'd0:    b = 8'h05;
					6'd1:    b = 8'h80;
					6'd2:    b = 8'h02;
					6'd3:    b = 8'h32;
					6'd4:    b = 8'd31;
					6'd5, 6'd6, 6'd7: b = 8'h00;
					default: b = ident_byte(idx);
				endcase
			end
			RSP_CAP: begin
				if (idx < 6'd4) begin
					b = be32_byte(d.sectors, idx[1:0]);
				end else begin
					b = be32_byte(32'(SECTOR_BYTES), idx[1:0]);
				end
			end
			RSP_TOC: begin
				case (idx)
					6'd1:    b = 8'd18;
					6'd2:    b = 8'd1;
					6'd3:    b = 8'd1;
					6'd5:    b = 8'h14;
					6'd6:    b = 8'd1;
					6'd13:   b = 8'h14;
					6'd14:   b = 8'hAA;
					6'd16, 6'd17, 6'd18, 6'd19: b = be32_byte(d.sectors, idx[1:0]);
					default: b = 8'h00;
				endcase
			end
			RSP_MODE: begin
				b = (idx == 6'd1) ? 8'd6 : 8'h00;
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/acp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_front: event and command front
// Accepts one word a cycle while the queue has room, updates the drive state
// and turns each command packet into a response descriptor for the queue.
// ----------------------------------------------------------------------------
module acp_front import acp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  opcode,
	input  wire logic [15:0] block_count,
	input  wire logic [27:0] buffer_bytes,
	input  wire logic        read_ok,
	input  wire logic [31:0] disc_sector_total,
	input  wire logic        q_full,
	output logic             push,
	output cmd_desc_t        push_desc
);

	logic [3:0]  key_q, key_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  qual_q, qual_d;
	logic        attn_q, attn_d;
	logic        media_q, media_d;
	logic [31:0] sectors_q, sectors_d;

	logic        accept;
	logic [31:0] need;
	logic [31:0] cap_last;
	cmd_desc_t   desc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign need     = 32'(block_count) * 32'(SECTOR_BYTES);
	assign cap_last = (sectors_q == 32'd0) ? 32'd0 : sectors_q - 32'd1;

	always_comb begin
		key_d     = key_q;
		code_d    = code_q;
		qual_d    = qual_q;
		attn_d    = attn_q;
		media_d   = media_q;
		sectors_d = sectors_q;

		desc.rsp     = RSP_NONE;
		desc.status  = 1'b0;
		desc.xfer    = '0;
		desc.key     = key_q;
		desc.code    = code_q;
		desc.qual    = qual_q;
		desc.sectors = sectors_q;

		case (kind)
			EV_RESET: begin
				key_d  = KEY_NONE;
				code_d = ASC_NONE;
				qual_d = 8'h00;
				attn_d = media_q;
			end
			EV_INSERT: begin
				media_d   = 1'b1;
				sectors_d = disc_sector_total;
				attn_d    = 1'b1;
			end
			EV_EJECT: begin
				media_d = 1'b0;
				attn_d  = 1'b0;
			end
			default: begin
				case (opcode)
					OP_TEST_UNIT_READY: begin
						qual_d = 8'h00;
						if (!media_q) begin
							key_d       = KEY_NOT_READY;
							code_d      = ASC_NO_MEDIUM;
							desc.status = 1'b1;
						end else if (attn_q) begin
							attn_d      = 1'b0;
							key_d       = KEY_ATTENTION;
							code_d      = ASC_DISC_CHANGED;
							desc.status = 1'b1;
						end else begin
							key_d  = KEY_NONE;
							code_d = ASC_NONE;
						end
					end
					OP_REQUEST_SENSE: begin
						if (buffer_bytes < 28'(LEN_SENSE)) begin
							desc.status = 1'b1;
						end else begin
							desc.rsp  = RSP_SENSE;
							desc.xfer = XFER_W'(LEN_SENSE);
							key_d     = KEY_NONE;
							code_d    = ASC_NONE;
							qual_d    = 8'h00;
						end
					end
					OP_INQUIRY: begin
						if (buffer_bytes < 28'(LEN_INQ)) begin
							desc.status = 1'b1;
						end else begin
							desc.rsp  = RSP_INQ;
							desc.xfer = XFER_W'(LEN_INQ);
						end
					end
					OP_READ_CAPACITY: begin
						if (buffer_bytes < 28'(LEN_CAP)) begin
							desc.status = 1'b1;
						end else if (!media_q) begin
							key_d       = KEY_NOT_READY;
							code_d      = ASC_NO_MEDIUM;
							qual_d      = 8'h00;
							desc.status = 1'b1;
						end else begin
							desc.rsp     = RSP_CAP;
							desc.xfer    = XFER_W'(LEN_CAP);
							desc.sectors = cap_last;
						end
					end
					OP_READ_TOC: begin
						if (buffer_bytes < 28'(LEN_TOC)) begin
							desc.status = 1'b1;
						end else if (!media_q) begin
							key_d       = KEY_NOT_READY;
							code_d      = ASC_NO_MEDIUM;
							qual_d      = 8'h00;
							desc.status = 1'b1;
						end else begin
							desc.rsp  = RSP_TOC;
							desc.xfer = XFER_W'(LEN_TOC);
						end
					end
					OP_MODE_SENSE10: begin
						if (buffer_bytes < 28'(LEN_MODE)) begin
							desc.status = 1'b1;
						end else begin
							desc.rsp  = RSP_MODE;
							desc.xfer = XFER_W'(LEN_MODE);
						end
					end
					OP_READ10: begin
						if (!media_q) begin
							key_d       = KEY_NOT_READY;
							code_d      = ASC_NO_MEDIUM;
							qual_d      = 8'h00;
							desc.status = 1'b1;
						end else if (block_count != 16'd0) begin
							qual_d = 8'h00;
							if (need > 32'(buffer_bytes)) begin
								key_d       = KEY_ILLEGAL;
								code_d      = ASC_INVALID_FIELD;
								desc.status = 1'b1;
							end else if (!read_ok) begin
								key_d       = KEY_ILLEGAL;
								code_d      = ASC_LBA_RANGE;
								desc.status = 1'b1;
							end else begin
								key_d     = KEY_NONE;
								code_d    = ASC_NONE;
								desc.xfer = (need > 32'(XFER_MAX)) ? XFER_MAX
									: need[XFER_W-1:0];
							end
						end
					end
					OP_START_STOP: begin
						desc.status = 1'b0;
					end
					default: begin
						key_d       = KEY_ILLEGAL;
						code_d      = ASC_INVALID_OPCODE;
						qual_d      = 8'h00;
						desc.status = 1'b1;
					end
				endcase
			end
		endcase
	end

	assign push      = accept && (kind == EV_CMD);
	assign push_desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= KEY_NONE;
			code_q    <= ASC_NONE;
			qual_q    <= 8'h00;
			attn_q    <= 1'b0;
			media_q   <= 1'b0;
			sectors_q <= 32'd0;
		end else if (accept) begin
			key_q     <= key_d;
			code_q    <= code_d;
			qual_q    <= qual_d;
			attn_q    <= attn_d;
			media_q   <= media_d;
			sectors_q <= sectors_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/acp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_queue: descriptor queue
// Short first-in first-out store of command descriptors between front and back.
// ----------------------------------------------------------------------------
module acp_queue import acp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_desc_t push_desc,
	output logic           full,
	input  wire logic      pop,
	output logic           q_valid,
	output cmd_desc_t      q_desc
);

	cmd_desc_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers wrap on their own: the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/acp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acp_back: response back end
// Takes descriptors from the queue and streams their status and response
// bytes into the output register, one word a cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module acp_back import acp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire cmd_desc_t          q_desc,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    status,
	output logic                    data_valid,
	output logic [7:0]              data_byte,
	output logic                    last,
	output logic [XFER_W-1:0]       transfer_bytes
);

	cmd_desc_t          cur_q;
	logic               cur_valid_q;
	logic [IDX_W-1:0]   idx_q;

	logic               out_valid_q;
	logic               status_q;
	logic               data_valid_q;
	logic [7:0]         data_byte_q;
	logic               last_q;
	logic [XFER_W-1:0]  xfer_q;

	logic               advance;
	logic               emit;
	logic               final_word;
	logic               has_data;

	assign advance    = !out_valid_q || !out_stall;
	assign emit       = cur_valid_q && advance;
	assign final_word = (idx_q == rsp_len(cur_q.rsp) - 6'd1);
	assign has_data   = (cur_q.rsp != RSP_NONE);
	assign pop        = q_valid && (!cur_valid_q || (emit && final_word));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				cur_valid_q <= !final_word;
				idx_q       <= idx_q + 6'd1;
			end
			if (advance) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_desc;
		end
		if (emit) begin
			status_q     <= cur_q.status;
			data_valid_q <= has_data;
			data_byte_q  <= has_data ? rsp_byte(cur_q, idx_q) : 8'h00;
			last_q       <= final_word;
			xfer_q       <= cur_q.xfer;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign data_valid     = data_valid_q;
	assign data_byte      = data_byte_q;
	assign last           = last_q;
	assign transfer_bytes = xfer_q;

endmodule
`default_nettype wire

>>> rtl/atapi_cdrom_command_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atapi_cdrom_command_responder: ATAPI CD-ROM packet command responder
// Command side of an ATAPI CD-ROM drive: events, sense state and responses.
// ----------------------------------------------------------------------------
// Feed one word per event or command packet on the input channel; kind picks
// command, device reset, media insert or media eject. Events update the drive
// state (sense key/ASC/ASCQ, unit attention, media presence, disc size) and
// return nothing. Each command returns either one word with data_valid low
// and last high (no-data commands and all failures), or one word per response
// byte with last on the final byte: INQUIRY 36, REQUEST SENSE 18, READ TOC 20,
// READ CAPACITY 8 and MODE SENSE(10) 8 bytes. transfer_bytes repeats the
// command's total length on every word; READ(10) reports its sector length
// without moving sector data, and lba does not affect the answer.
// Rate: the front takes a word every cycle while the descriptor queue has
// room, so events and commands are accepted back to back. The back drives
// one output word per cycle unless out_stall holds it, so a command occupies
// it for 1 to 36 output words (its response length); that single output port
// sets the sustained rate.
// ----------------------------------------------------------------------------
module atapi_cdrom_command_responder import acp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          kind,
	input  wire logic [7:0]          opcode,
	input  wire logic [31:0]         lba,
	input  wire logic [15:0]         block_count,
	input  wire logic [27:0]         buffer_bytes,
	input  wire logic                read_ok,
	input  wire logic [31:0]         disc_sector_total,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     status,
	output logic                     data_valid,
	output logic [7:0]               data_byte,
	output logic                     last,
	output logic [XFER_W-1:0]        transfer_bytes
);

	// Front to queue
	logic       push;
	cmd_desc_t  push_desc;
	logic       q_full;

	// Queue to back
	logic       q_valid;
	cmd_desc_t  q_desc;
	logic       pop;

	// Classify events and commands, hold the drive state. The READ(10)
	// start block is carried for completeness only; drop it here.
	acp_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.opcode            (opcode),
		.block_count       (block_count),
		.buffer_bytes      (buffer_bytes),
		.read_ok           (read_ok),
		.disc_sector_total (disc_sector_total),
		.q_full            (q_full),
		.push              (push),
		.push_desc         (push_desc)
	);

	// Hold pending commands so the front keeps going while a long response
	// is still streaming out.
	acp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_desc    (q_desc)
	);

	// Stream each command's response into the output register.
	acp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_desc         (q_desc),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_valid     (data_valid),
		.data_byte      (data_byte),
		.last           (last),
		.transfer_bytes (transfer_bytes)
	);

endmodule
`default_nettype wire
